FILE: sv/pep_pkg.sv
// shared types and constants for the pixel error propagation pipeline
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pep_pkg;

  // word format of pixel values, uncertainties and the result
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // derived widths
  localparam int PROD_W = 2 * DATA_WIDTH;            // one product of two magnitudes
  localparam int SQ_W   = 4 * DATA_WIDTH;            // a squared product
  localparam int RAD_W  = SQ_W + 2 * FRAC_BITS;      // radicand incl. divide-mode scaling
  localparam int ROOT_W = RAD_W / 2;                 // square root width
  localparam int REM_W  = ROOT_W + 2;                // square root partial remainder

  // operation codes of the mode register
  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_MUL = 2'd1,
    MODE_DIV = 2'd2
  } pep_mode_t;

  // sideband that travels with every item through the pipeline
  typedef struct packed {
    pep_mode_t          mode;
    logic               zero;
    logic [PROD_W-1:0]  dsq;
  } pep_tag_t;

  // one result item
  typedef struct packed {
    logic [DATA_WIDTH-1:0] prop_error;
    logic                  zero_operand;
    logic                  saturated;
  } pep_res_t;

endpackage

FILE: sv/pep_front.sv
// front end: operand magnitudes, products, squares and the radicand
// depends on pep_pkg
`timescale 1ns / 1ps

module pep_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  pep_pkg::pep_mode_t                    mode,
  input  logic signed [pep_pkg::DATA_WIDTH-1:0] value_a,
  input  logic signed [pep_pkg::DATA_WIDTH-1:0] value_b,
  input  logic signed [pep_pkg::DATA_WIDTH-1:0] err_a,
  input  logic signed [pep_pkg::DATA_WIDTH-1:0] err_b,
  output logic                                  rad_valid,
  output logic [pep_pkg::RAD_W-1:0]             rad,
  output pep_pkg::pep_tag_t                     tag
);
  import pep_pkg::*;

  function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] x);
    mag = x[DATA_WIDTH-1] ? (~x + 1'b1) : x;
  endfunction

  localparam int DW = DATA_WIDTH;

  // stage 0: magnitudes
  logic            v0_r, v1_r, v2_r, v3_r, v4_r;
  logic [DW-1:0]   ma_r, mb_r, mea_r, meb_r;
  pep_mode_t       mode0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ma_r    <= mag(value_a);
      mb_r    <= mag(value_b);
      mea_r   <= mag(err_a);
      meb_r   <= mag(err_b);
      mode0_r <= mode;
    end
  end

  // stage 1: cross products and divisor; add mode multiplies by one
  logic [DW-1:0]     sel_a, sel_b;
  logic [PROD_W-1:0] p1_nxt, q1_nxt, d1_nxt;
  logic [PROD_W-1:0] p1_r, q1_r;
  pep_tag_t          tag1_nxt, tag1_r;

  always_comb begin
    sel_a  = (mode0_r == MODE_ADD) ? DW'(1) : ma_r;
    sel_b  = (mode0_r == MODE_ADD) ? DW'(1) : mb_r;
    p1_nxt = sel_b * mea_r;
    q1_nxt = sel_a * meb_r;
    d1_nxt = mb_r * mb_r;
    tag1_nxt.mode = mode0_r;
    tag1_nxt.zero = (mode0_r == MODE_DIV) && ((ma_r == '0) || (mb_r == '0));
    tag1_nxt.dsq  = d1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r   <= p1_nxt;
      q1_r   <= q1_nxt;
      tag1_r <= tag1_nxt;
    end
  end

  // stage 2: partial products of the squares
  logic [PROD_W-1:0] phh_nxt, phl_nxt, pll_nxt, qhh_nxt, qhl_nxt, qll_nxt;
  logic [PROD_W-1:0] phh_r, phl_r, pll_r, qhh_r, qhl_r, qll_r;
  pep_tag_t          tag2_r;

  always_comb begin
    phh_nxt = p1_r[PROD_W-1:DW] * p1_r[PROD_W-1:DW];
    phl_nxt = p1_r[PROD_W-1:DW] * p1_r[DW-1:0];
    pll_nxt = p1_r[DW-1:0] * p1_r[DW-1:0];
    qhh_nxt = q1_r[PROD_W-1:DW] * q1_r[PROD_W-1:DW];
    qhl_nxt = q1_r[PROD_W-1:DW] * q1_r[DW-1:0];
    qll_nxt = q1_r[DW-1:0] * q1_r[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      phh_r  <= phh_nxt;
      phl_r  <= phl_nxt;
      pll_r  <= pll_nxt;
      qhh_r  <= qhh_nxt;
      qhl_r  <= qhl_nxt;
      qll_r  <= qll_nxt;
      tag2_r <= tag1_r;
    end
  end

  // stage 3: assemble both squares
  logic [SQ_W-1:0] p2_nxt, q2_nxt, p2_r, q2_r;
  pep_tag_t        tag3_r;

  always_comb begin
    p2_nxt = {phh_r, PROD_W'(0)} + (SQ_W'(phl_r) << (DW + 1)) + SQ_W'(pll_r);
    q2_nxt = {qhh_r, PROD_W'(0)} + (SQ_W'(qhl_r) << (DW + 1)) + SQ_W'(qll_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_r   <= p2_nxt;
      q2_r   <= q2_nxt;
      tag3_r <= tag2_r;
    end
  end

  // stage 4: sum of squares, scaled up in divide mode
  logic [SQ_W-1:0]  sum;
  logic [RAD_W-1:0] rad4_nxt, rad4_r;
  pep_tag_t         tag4_r;

  always_comb begin
    sum = p2_r + q2_r;
    if (tag3_r.mode == MODE_DIV) begin
      rad4_nxt = RAD_W'(sum) << (2 * FRAC_BITS);
    end else begin
      rad4_nxt = RAD_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad4_r <= rad4_nxt;
      tag4_r <= tag3_r;
    end
  end

  assign rad_valid = v4_r;
  assign rad       = rad4_r;
  assign tag       = tag4_r;

endmodule

FILE: sv/pep_sqrt.sv
// pipelined integer square root, one root bit per stage
// depends on pep_pkg
`timescale 1ns / 1ps

module pep_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         rad_valid,
  input  logic [pep_pkg::RAD_W-1:0]    rad,
  input  pep_pkg::pep_tag_t            tag_i,
  output logic                         root_valid,
  output logic [pep_pkg::ROOT_W-1:0]   root,
  output pep_pkg::pep_tag_t            tag_o
);
  import pep_pkg::*;

  logic              v_r    [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  pep_tag_t          tag_r  [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic              v_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    pep_tag_t          tag_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    // stage input: pipeline entry or previous stage
    if (i == 0) begin : g_first
      assign v_in    = rad_valid;
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign tag_in  = tag_r[i-1];
    end

    // bring down two radicand bits and try the next root bit
    always_comb begin
      rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
      trial  = {root_in, 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[i]  <= rad_in << 2;
        rem_r[i]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[i] <= {root_in[ROOT_W-2:0], ge};
        tag_r[i]  <= tag_in;
      end
    end
  end

  assign root_valid = v_r[ROOT_W-1];
  assign root       = root_r[ROOT_W-1];
  assign tag_o      = tag_r[ROOT_W-1];

endmodule

FILE: sv/pep_div.sv
// result scaling, range check and pipelined restoring divide for divide mode
// depends on pep_pkg
`timescale 1ns / 1ps

module pep_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        root_valid,
  input  logic [pep_pkg::ROOT_W-1:0]  root,
  input  pep_pkg::pep_tag_t           tag_i,
  output logic                        res_valid,
  output pep_pkg::pep_res_t           res
);
  import pep_pkg::*;

  localparam int DW = DATA_WIDTH;

  // head stage: scaled root for add and multiply, overflow checks
  logic              over_nxt;
  logic [DW-1:0]     am_nxt;
  logic [ROOT_W-1:0] root_hi;
  logic              hv_r;
  logic              hover_r;
  logic [DW-1:0]     ham_r;
  logic [PROD_W-1:0] hrem_r;
  logic [DW-1:0]     hlow_r;
  pep_tag_t          htag_r;

  always_comb begin
    root_hi = root >> DW;
    am_nxt  = '0;
    case (tag_i.mode)
      MODE_ADD: begin
        over_nxt = |root[ROOT_W-1:DW];
        am_nxt   = root[DW-1:0];
      end
      MODE_MUL: begin
        over_nxt = |root[ROOT_W-1:DW+FRAC_BITS];
        am_nxt   = root[DW+FRAC_BITS-1:FRAC_BITS];
      end
      MODE_DIV: begin
        over_nxt = (root_hi >= ROOT_W'(tag_i.dsq));
      end
      default: begin
        over_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
    end else if (adv) begin
      hv_r <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hover_r <= over_nxt;
      ham_r   <= am_nxt;
      hrem_r  <= PROD_W'(root_hi);
      hlow_r  <= root[DW-1:0];
      htag_r  <= tag_i;
    end
  end

  // one quotient bit per stage
  logic              v_r    [DW];
  logic              over_r [DW];
  logic [DW-1:0]     am_r   [DW];
  logic [PROD_W-1:0] rem_r  [DW];
  logic [DW-1:0]     low_r  [DW];
  logic [DW-1:0]     quo_r  [DW];
  pep_tag_t          tag_r  [DW];

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic              v_in;
    logic              over_in;
    logic [DW-1:0]     am_in;
    logic [PROD_W-1:0] rem_in;
    logic [DW-1:0]     low_in;
    logic [DW-1:0]     quo_in;
    pep_tag_t          tag_in;
    logic [PROD_W:0]   rem_sh;
    logic [PROD_W:0]   dvs;
    logic              ge;
    logic [PROD_W:0]   diff;

    if (i == 0) begin : g_first
      assign v_in    = hv_r;
      assign over_in = hover_r;
      assign am_in   = ham_r;
      assign rem_in  = hrem_r;
      assign low_in  = hlow_r;
      assign quo_in  = '0;
      assign tag_in  = htag_r;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign over_in = over_r[i-1];
      assign am_in   = am_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign low_in  = low_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign tag_in  = tag_r[i-1];
    end

    // shift in the next dividend bit, subtract the divisor if it fits
    always_comb begin
      rem_sh = {rem_in, low_in[DW-1]};
      dvs    = {1'b0, tag_in.dsq};
      ge     = (rem_sh >= dvs);
      diff   = rem_sh - dvs;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (adv) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        over_r[i] <= over_in;
        am_r[i]   <= am_in;
        rem_r[i]  <= ge ? diff[PROD_W-1:0] : rem_sh[PROD_W-1:0];
        low_r[i]  <= low_in << 1;
        quo_r[i]  <= {quo_in[DW-2:0], ge};
        tag_r[i]  <= tag_in;
      end
    end
  end

  // final selection of the result item
  always_comb begin
    res = '0;
    if (tag_r[DW-1].zero) begin
      res.zero_operand = 1'b1;
    end else begin
      case (tag_r[DW-1].mode) inside
        MODE_ADD, MODE_MUL: begin
          res.saturated  = over_r[DW-1];
          res.prop_error = over_r[DW-1] ? '1 : am_r[DW-1];
        end
        MODE_DIV: begin
          res.saturated  = over_r[DW-1];
          res.prop_error = over_r[DW-1] ? '1 : quo_r[DW-1];
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  assign res_valid = v_r[DW-1];

endmodule

FILE: sv/pixel_error_propagation.sv
// top level of the pixel error propagation pipeline: mode register,
// pipeline sections and output register with skid stage; depends on pep_pkg,
// pep_front, pep_sqrt and pep_div
//
//   channel   direction   handshake            payload
//   in_       input       in_valid / in_stall  in_value_a, in_value_b, in_err_a, in_err_b
//   out_      output      out_valid / out_stall out_prop_error, out_zero_operand, out_saturated
//   cfg_      input       cfg_wr_en            cfg_wr_data (operation mode)
//
// one item is accepted per cycle while in_stall is low; the pipeline is 5 front stages,
// 2*DATA_WIDTH+FRAC_BITS square root stages (80), 1+DATA_WIDTH divide stages (33) and the
// output register; the square root pipeline is the deepest section
// reset is synchronous, active low, and clears every valid bit and the mode to add
// the whole pipeline holds while the skid stage is full; in_stall is that flag,
// so one result may wait at the output while the next items keep flowing
`timescale 1ns / 1ps

module pixel_error_propagation (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [1:0]                            cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [pep_pkg::DATA_WIDTH-1:0] in_value_a,
  input  logic signed [pep_pkg::DATA_WIDTH-1:0] in_value_b,
  input  logic signed [pep_pkg::DATA_WIDTH-1:0] in_err_a,
  input  logic signed [pep_pkg::DATA_WIDTH-1:0] in_err_b,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [pep_pkg::DATA_WIDTH-1:0]        out_prop_error,
  output logic                                  out_zero_operand,
  output logic                                  out_saturated
);
  import pep_pkg::*;

  // mode register
  pep_mode_t mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ADD;
    end else if (cfg_wr_en) begin
      mode_r <= pep_mode_t'(cfg_wr_data);
    end
  end

  // pipeline advance
  logic skid_valid_r;
  logic adv;

  assign adv      = ~skid_valid_r;
  assign in_stall = skid_valid_r;

  // pipeline sections
  logic              rad_valid;
  logic [RAD_W-1:0]  rad;
  pep_tag_t          rad_tag;
  logic              root_valid;
  logic [ROOT_W-1:0] root;
  pep_tag_t          root_tag;
  logic              res_valid;
  pep_res_t          res;

  pep_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .mode      (mode_r),
    .value_a   (in_value_a),
    .value_b   (in_value_b),
    .err_a     (in_err_a),
    .err_b     (in_err_b),
    .rad_valid (rad_valid),
    .rad       (rad),
    .tag       (rad_tag)
  );

  pep_sqrt u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .rad_valid  (rad_valid),
    .rad        (rad),
    .tag_i      (rad_tag),
    .root_valid (root_valid),
    .root       (root),
    .tag_o      (root_tag)
  );

  pep_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .root_valid (root_valid),
    .root       (root),
    .tag_i      (root_tag),
    .res_valid  (res_valid),
    .res        (res)
  );

  // output register and skid stage
  logic     out_valid_r;
  pep_res_t out_res_r, skid_res_r;
  logic     take;
  logic     out_free;

  assign take     = out_valid_r & ~out_stall;
  assign out_free = ~out_valid_r | take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_free) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_free) begin
        out_res_r <= skid_res_r;
      end
    end else if (res_valid) begin
      if (out_free) begin
        out_res_r <= res;
      end else begin
        skid_res_r <= res;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_prop_error   = out_res_r.prop_error;
  assign out_zero_operand = out_res_r.zero_operand;
  assign out_saturated    = out_res_r.saturated;

endmodule
